>>> hw/rtl/cmdcrc_pkg.sv
// Shared types, codes and CRC helper for the command CRC16 framer.
package cmdcrc_pkg;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	localparam logic [7:0] OP_PROGRAM  = 8'h82;
	localparam logic [7:0] OP_CRC_ON   = 8'h6a;
	localparam logic [7:0] OP_NOCRC_A  = 8'hfd;
	localparam logic [7:0] OP_NOCRC_B  = 8'hf0;
	localparam logic [7:0] OP_NOCRC_C  = 8'h3c;
	localparam logic [7:0] OP_NOCRC_D  = 8'h79;

	localparam logic [7:0] STAT_BUSY_MASK = 8'h02;
	localparam logic [7:0] STAT_PROG_MASK = 8'h01;

	localparam logic ACT_BYTE   = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

	localparam logic KIND_TX      = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [1:0] VD_SUCCESS   = 2'd0;
	localparam logic [1:0] VD_RESEND    = 2'd1;
	localparam logic [1:0] VD_XFER_ERR  = 2'd2;
	localparam logic [1:0] VD_EXHAUSTED = 2'd3;

	localparam logic REG_CRC_ENABLE  = 1'b0;
	localparam logic REG_RETRY_LIMIT = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       last;
		logic       xfer_ok;
		logic [7:0] status_byte;
	} in_beat_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] tx_byte;
		logic       tx_last;
		logic [1:0] verdict;
		logic       crc_used;
		logic [2:0] attempt;
	} out_beat_t;

	typedef struct packed {
		logic       crc_enable;
		logic [2:0] retry_limit;
	} cfg_t;

	// One queued job: a command byte (maybe with CRC tail) or a verdict.
	typedef struct packed {
		logic        is_verdict;
		logic [7:0]  data_byte;
		logic        byte_last;
		logic        crc_follow;
		logic [15:0] crc;
		logic [1:0]  verdict;
		logic        crc_used;
		logic [2:0]  attempt;
	} job_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/cmdcrc_front.sv
// Front end: accepts input beats, tracks frame state and CRC, emits jobs.
module cmdcrc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmdcrc_pkg::cfg_t      cfg,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmdcrc_pkg::in_beat_t  cmd,
	input  logic                  full,
	output logic                  push,
	output cmdcrc_pkg::job_t      push_job
);

	logic        at_start_q;
	logic        mode_q;
	logic        prog_q;
	logic [15:0] crc_q;
	logic [2:0]  attempt_q;

	logic        mode_new;
	logic        mode_eff;
	logic        prog_eff;
	logic [15:0] crc_base;
	logic [15:0] crc_new;
	logic [2:0]  attempts;
	logic        pass;
	logic [1:0]  vd;
	logic [2:0]  attempt_next;

	assign cmd_ready = !full;
	assign push      = cmd_valid && cmd_ready;

	always_comb begin
		case (cmd.data_byte)
			cmdcrc_pkg::OP_PROGRAM, cmdcrc_pkg::OP_CRC_ON: mode_new = 1'b1;
			cmdcrc_pkg::OP_NOCRC_A, cmdcrc_pkg::OP_NOCRC_B,
			cmdcrc_pkg::OP_NOCRC_C, cmdcrc_pkg::OP_NOCRC_D: mode_new = 1'b0;
			default: mode_new = cfg.crc_enable;
		endcase
	end

	assign mode_eff = at_start_q ? mode_new : mode_q;
	assign prog_eff = at_start_q ? (cmd.data_byte == cmdcrc_pkg::OP_PROGRAM) : prog_q;
	assign crc_base = at_start_q ? cmdcrc_pkg::CRC_INIT : crc_q;
	assign crc_new  = cmdcrc_pkg::crc_update(crc_base, cmd.data_byte);

	assign attempts = attempt_q + 3'd1;
	assign pass     = prog_q ? ((cmd.status_byte & cmdcrc_pkg::STAT_PROG_MASK) != 8'h00)
	                         : ((cmd.status_byte & cmdcrc_pkg::STAT_BUSY_MASK) == 8'h00);

	always_comb begin
		attempt_next = 3'd0;
		if (!mode_q) begin
			vd = cmd.xfer_ok ? cmdcrc_pkg::VD_SUCCESS : cmdcrc_pkg::VD_XFER_ERR;
		end else if (!cmd.xfer_ok) begin
			vd = cmdcrc_pkg::VD_XFER_ERR;
		end else if (pass) begin
			vd = cmdcrc_pkg::VD_SUCCESS;
		end else if (attempts >= cfg.retry_limit) begin
			vd = cmdcrc_pkg::VD_EXHAUSTED;
		end else begin
			vd = cmdcrc_pkg::VD_RESEND;
			attempt_next = attempts;
		end
	end

	always_comb begin
		if (cmd.action == cmdcrc_pkg::ACT_BYTE) begin
			push_job.is_verdict = 1'b0;
			push_job.data_byte  = cmd.data_byte;
			push_job.byte_last  = cmd.last && !mode_eff;
			push_job.crc_follow = cmd.last && mode_eff;
			push_job.crc        = crc_new;
			push_job.verdict    = cmdcrc_pkg::VD_SUCCESS;
			push_job.crc_used   = mode_eff;
			push_job.attempt    = attempt_q;
		end else begin
			push_job.is_verdict = 1'b1;
			push_job.data_byte  = 8'h00;
			push_job.byte_last  = 1'b0;
			push_job.crc_follow = 1'b0;
			push_job.crc        = crc_q;
			push_job.verdict    = vd;
			push_job.crc_used   = mode_q;
			push_job.attempt    = attempts;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			mode_q     <= 1'b0;
			prog_q     <= 1'b0;
			crc_q      <= cmdcrc_pkg::CRC_INIT;
			attempt_q  <= 3'd0;
		end else if (push) begin
			if (cmd.action == cmdcrc_pkg::ACT_BYTE) begin
				at_start_q <= cmd.last;
				mode_q     <= mode_eff;
				prog_q     <= prog_eff;
				crc_q      <= crc_new;
			end else begin
				attempt_q  <= attempt_next;
			end
		end
	end

endmodule

>>> hw/rtl/cmdcrc_fifo.sv
// Short job queue between the front and back ends.
module cmdcrc_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  cmdcrc_pkg::job_t           push_data,
	input  logic                       pop,
	output cmdcrc_pkg::job_t           head,
	output logic                       valid,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	cmdcrc_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    count_q;

	assign head  = mem_q[rd_q];
	assign valid = count_q != CW'(0);
	assign full  = count_q == CW'(DEPTH);
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hw/rtl/cmdcrc_back.sv
// Back end: expands queued jobs into result beats through an output register.
module cmdcrc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmdcrc_pkg::job_t       head,
	input  logic                   head_valid,
	output logic                   pop,
	output logic                   res_valid,
	input  logic                   res_ready,
	output cmdcrc_pkg::out_beat_t  res
);

	localparam logic [1:0] PH_BYTE   = 2'd0;
	localparam logic [1:0] PH_CRC_LO = 2'd1;
	localparam logic [1:0] PH_CRC_HI = 2'd2;

	logic [1:0]            phase_q;
	logic                  res_valid_q;
	cmdcrc_pkg::out_beat_t res_q;
	cmdcrc_pkg::out_beat_t beat;
	logic                  load;
	logic                  final_beat;

	assign load       = head_valid && (!res_valid_q || res_ready);
	assign final_beat = head.is_verdict || !head.crc_follow || (phase_q == PH_CRC_HI);
	assign pop        = load && final_beat;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_comb begin
		beat.kind     = head.is_verdict ? cmdcrc_pkg::KIND_VERDICT : cmdcrc_pkg::KIND_TX;
		beat.verdict  = head.verdict;
		beat.crc_used = head.crc_used;
		beat.attempt  = head.attempt;
		case (phase_q)
			PH_CRC_LO: begin
				beat.tx_byte = head.crc[7:0];
				beat.tx_last = 1'b0;
			end
			PH_CRC_HI: begin
				beat.tx_byte = head.crc[15:8];
				beat.tx_last = 1'b1;
			end
			default: begin
				beat.tx_byte = head.data_byte;
				beat.tx_last = head.byte_last;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_BYTE;
			res_valid_q <= 1'b0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
				phase_q     <= final_beat ? PH_BYTE : phase_q + 2'd1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/command_crc16_framer_with_retry.sv
// Top level of the command CRC16 framer with retry verdicts.
// Each input beat is taken while the job queue (QDEPTH entries) has room; the
// front end runs the CRC over the whole byte as the beat is taken. A command
// byte yields one result beat, the last byte of a CRC frame three (byte, CRC low,
// CRC high), and a transfer report one verdict beat. The back end delivers one
// result beat per cycle through its output register while res_ready is high,
// so sustained input rate is one beat per cycle, lower while the last byte of a
// CRC frame goes out as three beats. Registers: crc_enable 0x0, retry_limit 0x4.
module command_crc16_framer_with_retry #(
	parameter int QDEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmdcrc_pkg::in_beat_t  cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output cmdcrc_pkg::out_beat_t res
);

	cmdcrc_pkg::cfg_t cfg_q;
	cmdcrc_pkg::job_t push_job;
	cmdcrc_pkg::job_t head;
	logic             push;
	logic             pop;
	logic             q_valid;
	logic             q_full;
	logic [$clog2(QDEPTH+1)-1:0] q_count;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign prdata = (paddr[2] == cmdcrc_pkg::REG_RETRY_LIMIT) ?
	                {29'd0, cfg_q.retry_limit} : {31'd0, cfg_q.crc_enable};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_enable  <= 1'b0;
			cfg_q.retry_limit <= 3'd3;
		end else if (wr_en) begin
			if (paddr[2] == cmdcrc_pkg::REG_CRC_ENABLE) begin
				cfg_q.crc_enable <= pwdata[0];
			end else begin
				cfg_q.retry_limit <= pwdata[2:0];
			end
		end
	end

	cmdcrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.full      (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	cmdcrc_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.pop       (pop),
		.head      (head),
		.valid     (q_valid),
		.full      (q_full),
		.count     (q_count)
	);

	cmdcrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (q_valid),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	a_verdict_no_tx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == cmdcrc_pkg::KIND_VERDICT |->
			res.tx_byte == 8'h00 && !res.tx_last)
		else $error("verdict beat carries transmit fields");

	a_resend_needs_crc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == cmdcrc_pkg::KIND_VERDICT &&
			res.verdict == cmdcrc_pkg::VD_RESEND |-> res.crc_used)
		else $error("resend on a frame without CRC");

	a_verdict_attempt: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == cmdcrc_pkg::KIND_VERDICT |-> res.attempt != 3'd0)
		else $error("verdict with zero attempts");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> q_count != ($bits(q_count))'(QDEPTH))
		else $error("push into full job queue");

endmodule
